/* hdl/prds_pkg.sv */
// Shared constants, types and the RGB565 packing function for the palette scaler.
package prds_pkg;

    localparam int ADDR_W  = 17;
    localparam int COLOR_W = 16;
    localparam int CHAN_W  = 8;

    localparam int DEF_SRC_WIDTH     = 120;
    localparam int DEF_SRC_HEIGHT    = 160;
    localparam int DEF_DST_WIDTH     = 240;
    localparam int DEF_PALETTE_DEPTH = 256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Position of a write within the 2x2 block
    typedef enum logic [1:0] {
        BEAT_TL = 2'd0,
        BEAT_TR = 2'd1,
        BEAT_BL = 2'd2,
        BEAT_BR = 2'd3
    } beat_t;

    function automatic logic [COLOR_W-1:0] pack565(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

/* hdl/prds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module prds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/palette_rgb565_double_scaler_unit.sv */
// Palette lookup and 2x2 pixel replication for an RGB565 display (top level).
//
//  channel | signals                                          | dir | word
//  --------+--------------------------------------------------+-----+---------------------------
//  input   | in_valid/in_ready, cmd, entry_number, red, green, | in  | palette load or one pixel
//          | blue, pixel_index, src_col, src_row              |     |
//  output  | out_valid/out_ready, dst_address, color, last    | out | one display write
//
//  A load word writes the palette RAM at its acceptance edge.
//  An on-source pixel word reads the RAM at acceptance, waits in a holding stage, then gives
//  four writes from the output register, which takes a new pixel only when its block ends.
//  Loads and off-source pixels are taken every cycle while the holding stage has room.
//  Reset clears the control state only; the palette holds garbage until loaded.
//  A stalled output holds its word and backs up into the holding stage, then the input.
module palette_rgb565_double_scaler_unit
    import prds_pkg::*;
#(
    parameter int SRC_WIDTH     = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT    = DEF_SRC_HEIGHT,
    parameter int DST_WIDTH     = DEF_DST_WIDTH,
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [7:0]         entry_number,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         pixel_index,
    input  logic [6:0]         src_col,
    input  logic [7:0]         src_row,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  dst_address,
    output logic [COLOR_W-1:0] color,
    output logic               last
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam logic [ADDR_W-1:0] DST_W_A = ADDR_W'(DST_WIDTH);

    logic                in_fire;
    logic                load_we;
    logic                pix_take;
    logic                pix_on_src;
    logic [ADDR_W-1:0]   pix_base;
    logic [COLOR_W-1:0]  pal_rdata;

    // Holding stage
    logic                a_valid_reg, a_valid_next;
    logic [ADDR_W-1:0]   a_base_reg;
    logic                a_hit_reg;
    logic                a_move;

    // Output register
    logic                out_valid_reg, out_valid_next;
    beat_t               beat_reg, beat_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   dst_address_reg, dst_address_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    assign load_we    = in_fire && (cmd == CMD_LOAD) && (32'(entry_number) < PALETTE_DEPTH);
    assign pix_on_src = (32'(src_col) < SRC_WIDTH) && (32'(src_row) < SRC_HEIGHT);
    assign pix_take   = in_fire && (cmd == CMD_PIXEL) && pix_on_src;
    assign pix_base   = ADDR_W'({src_row, 1'b0}) * DST_W_A + ADDR_W'({src_col, 1'b0});

    prds_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (load_we),
        .waddr (entry_number[PAL_AW-1:0]),
        .wdata (pack565(red, green, blue)),
        .re    (pix_take),
        .raddr (pixel_index[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    // Advance the held pixel once the output register is empty or finishing its block
    assign a_move   = a_valid_reg && (!out_valid_reg || (out_fire && beat_reg == BEAT_BR));
    assign in_ready = !a_valid_reg || a_move;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (pix_take)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            a_base_reg <= pix_base;
            a_hit_reg  <= (32'(pixel_index) < PALETTE_DEPTH);
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        beat_next        = beat_reg;
        base_next        = base_reg;
        dst_address_next = dst_address_reg;
        color_next       = color_reg;
        if (a_move)
        begin
            out_valid_next   = 1'b1;
            beat_next        = BEAT_TL;
            base_next        = a_base_reg;
            dst_address_next = a_base_reg;
            color_next       = a_hit_reg ? pal_rdata : '0;
        end
        else if (out_fire)
        begin
            case (beat_reg)
                BEAT_TL:
                begin
                    beat_next        = BEAT_TR;
                    dst_address_next = base_reg + ADDR_W'(1);
                end
                BEAT_TR:
                begin
                    beat_next        = BEAT_BL;
                    dst_address_next = base_reg + DST_W_A;
                end
                BEAT_BL:
                begin
                    beat_next        = BEAT_BR;
                    dst_address_next = base_reg + DST_W_A + ADDR_W'(1);
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= BEAT_TL;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg        <= base_next;
        dst_address_reg <= dst_address_next;
        color_reg       <= color_next;
    end

    assign out_valid   = out_valid_reg;
    assign dst_address = dst_address_reg;
    assign color       = color_reg;
    assign last        = (beat_reg == BEAT_BR);

    // A block that is not finished keeps its output word pending
    a_block_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && beat_reg != BEAT_BR |=> out_valid_reg)
        else $error("output dropped before the fourth write");

    // A pixel handed to the output register starts at the top-left write
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        a_move |=> out_valid_reg && beat_reg == BEAT_TL && dst_address_reg == base_reg)
        else $error("block did not start at its top-left write");

    // A held pixel keeps its address while the output register is busy
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_move |=> a_valid_reg && $stable(a_base_reg))
        else $error("held pixel lost or changed");

endmodule
